### rtl/alrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm clock controller package
// Shared item kinds, register indexes, field widths and the picker state type.
// ----------------------------------------------------------------------------
package alrm_pkg;

   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int JOY_W    = 14;
   localparam int CSR_IDX_W = 2;

   localparam logic [HOUR_W-1:0]   LAST_HOUR      = 5'd23;
   localparam logic [MINUTE_W-1:0] LAST_MINUTE    = 6'd59;
   localparam logic [HOUR_W:0]     HOURS_PER_DAY  = 6'd24;
   localparam logic [MINUTE_W:0]   MINS_PER_HOUR  = 7'd60;
   localparam logic [MINUTE_W:0]   MINS_PER_2HOUR = 7'd120;

   localparam logic [JOY_W-1:0]    JOY_LO_RST = 14'd5000;
   localparam logic [JOY_W-1:0]    JOY_HI_RST = 14'd12000;
   localparam logic [MINUTE_W-1:0] SNOOZE_RST = 6'd1;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_JOY    = 2'd1,
      REQ_SET    = 2'd2,
      REQ_SNOOZE = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JOY_LO = 2'd0,
      CSR_JOY_HI = 2'd1,
      CSR_SNOOZE = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic                column;
      logic                rearmed;
   } picker_type;

endpackage : alrm_pkg
`default_nettype wire

### rtl/alrm_picker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm picker update
// Joystick column select and one-shot hour/minute stepping with wrap.
// ----------------------------------------------------------------------------
module alrm_picker
   import alrm_pkg::*;
(
   input  picker_type       cur,
   input  logic [JOY_W-1:0] joy_x,
   input  logic [JOY_W-1:0] joy_y,
   input  logic [JOY_W-1:0] lo_level,
   input  logic [JOY_W-1:0] hi_level,
   output picker_type       nxt
);

   logic col;
   logic step_down;
   logic step_up;
   logic in_band;

   always_comb begin
      priority if (joy_x < lo_level) begin
         col = 1'b0;
      end else if (joy_x > hi_level) begin
         col = 1'b1;
      end else begin
         col = cur.column;
      end
   end

   // low is tested before high
   assign step_down = (joy_y < lo_level) && cur.rearmed;
   assign step_up   = !step_down && (joy_y > hi_level) && cur.rearmed;
   assign in_band   = (joy_y >= lo_level) && (joy_y <= hi_level);

   always_comb begin
      nxt        = cur;
      nxt.column = col;
      if (step_down) begin
         if (!col) begin
            nxt.hour = (cur.hour == '0) ? LAST_HOUR : cur.hour - HOUR_W'(1);
         end else begin
            nxt.minute = (cur.minute == '0) ? LAST_MINUTE : cur.minute - MINUTE_W'(1);
         end
         nxt.rearmed = 1'b0;
      end else if (step_up) begin
         if (!col) begin
            nxt.hour = (cur.hour == LAST_HOUR) ? '0 : cur.hour + HOUR_W'(1);
         end else begin
            nxt.minute = (cur.minute == LAST_MINUTE) ? '0 : cur.minute + MINUTE_W'(1);
         end
         nxt.rearmed = 1'b0;
      end else if (in_band) begin
         nxt.rearmed = 1'b1;
      end
   end

endmodule : alrm_picker
`default_nettype wire

### rtl/alrm_snooze.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snooze time adder
// Clock time plus snooze minutes, minute mod 60 and hour mod 24.
// ----------------------------------------------------------------------------
module alrm_snooze
   import alrm_pkg::*;
(
   input  logic [HOUR_W-1:0]   clock_hour,
   input  logic [MINUTE_W-1:0] clock_minute,
   input  logic [MINUTE_W-1:0] snooze_minutes,
   output logic [HOUR_W-1:0]   wake_hour,
   output logic [MINUTE_W-1:0] wake_minute
);

   logic [MINUTE_W:0] min_sum;
   logic [MINUTE_W:0] min_wrap;
   logic [1:0]        carry;
   logic [HOUR_W:0]   hour_sum;
   logic [HOUR_W:0]   hour_wrap;

   // sum of two 6-bit values stays below 128, so at most two hours carry
   assign min_sum = {1'b0, clock_minute} + {1'b0, snooze_minutes};

   always_comb begin
      priority if (min_sum >= MINS_PER_2HOUR) begin
         min_wrap = min_sum - MINS_PER_2HOUR;
         carry    = 2'd2;
      end else if (min_sum >= MINS_PER_HOUR) begin
         min_wrap = min_sum - MINS_PER_HOUR;
         carry    = 2'd1;
      end else begin
         min_wrap = min_sum;
         carry    = 2'd0;
      end
   end

   // hour sum stays below 48, one subtract is enough
   assign hour_sum  = {1'b0, clock_hour} + {{(HOUR_W-1){1'b0}}, carry};
   assign hour_wrap = (hour_sum >= HOURS_PER_DAY) ? hour_sum - HOURS_PER_DAY : hour_sum;

   assign wake_hour   = hour_wrap[HOUR_W-1:0];
   assign wake_minute = min_wrap[MINUTE_W-1:0];

endmodule : alrm_snooze
`default_nettype wire

### rtl/alarm_clock_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm clock controller
// Hour/minute picker, armed alarm time, ringing flag with stop and snooze.
// ----------------------------------------------------------------------------
// Each request item (clock tick, joystick sample, stop/set button, snooze
// button) is captured in an input register, applied to the alarm state when
// it moves to the result register, and answered by exactly one result item
// holding the updated state: armed flag, ringing flag (the buzzer enable),
// picker hour/minute/column and the alarm time. Throughput is one item per
// clock while rsp_stall stays low. The input and result registers decouple
// the two channels, so a new item is taken while a result waits, and
// req_stall rises only when both registers are full and rsp_stall is high.
// Thresholds and the snooze length are written through the csr_ port, which
// is always ready; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module alarm_clock_controller
   import alrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [JOY_W-1:0]     csr_data,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic [HOUR_W-1:0]    req_clock_hour,
   input  logic [MINUTE_W-1:0]  req_clock_minute,
   input  logic [SECOND_W-1:0]  req_clock_second,
   input  logic [JOY_W-1:0]     req_joy_x,
   input  logic [JOY_W-1:0]     req_joy_y,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_alarm_armed,
   output logic                 rsp_ringing,
   output logic [HOUR_W-1:0]    rsp_edit_hour,
   output logic [MINUTE_W-1:0]  rsp_edit_minute,
   output logic                 rsp_column,
   output logic [HOUR_W-1:0]    rsp_alarm_hour,
   output logic [MINUTE_W-1:0]  rsp_alarm_minute
);

   // ---------------------------------------------------------------- config
   logic [JOY_W-1:0]    lo_level_ff, lo_level_in;
   logic [JOY_W-1:0]    hi_level_ff, hi_level_in;
   logic [MINUTE_W-1:0] snooze_ff,   snooze_in;

   assign csr_ready = 1'b1;

   always_comb begin
      lo_level_in = lo_level_ff;
      hi_level_in = hi_level_ff;
      snooze_in   = snooze_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_JOY_LO: lo_level_in = csr_data;
            CSR_JOY_HI: hi_level_in = csr_data;
            CSR_SNOOZE: snooze_in   = csr_data[MINUTE_W-1:0];
            CSR_UNUSED: ;  // drop writes to the unused index
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_level_ff <= JOY_LO_RST;
         hi_level_ff <= JOY_HI_RST;
         snooze_ff   <= SNOOZE_RST;
      end else begin
         lo_level_ff <= lo_level_in;
         hi_level_ff <= hi_level_in;
         snooze_ff   <= snooze_in;
      end
   end

   // ------------------------------------------------------------ handshake
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;   // result register can load this cycle
   logic in_go;      // apply the held item to the state
   logic req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_go     = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_go) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (in_go) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ------------------------------------------------------- input register
   logic [1:0]          type_ff;
   logic [HOUR_W-1:0]   hour_ff;
   logic [MINUTE_W-1:0] minute_ff;
   logic [SECOND_W-1:0] second_ff;
   logic [JOY_W-1:0]    joy_x_ff;
   logic [JOY_W-1:0]    joy_y_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         type_ff   <= req_type;
         hour_ff   <= req_clock_hour;
         minute_ff <= req_clock_minute;
         second_ff <= req_clock_second;
         joy_x_ff  <= req_joy_x;
         joy_y_ff  <= req_joy_y;
      end
   end

   // ---------------------------------------------------------- alarm state
   picker_type          picker_ff, picker_in, picker_joy;
   logic [HOUR_W-1:0]   target_hour_ff, target_hour_in;
   logic [MINUTE_W-1:0] target_minute_ff, target_minute_in;
   logic                armed_ff, armed_in;
   logic                ringing_ff, ringing_in;
   logic [HOUR_W-1:0]   wake_hour;
   logic [MINUTE_W-1:0] wake_minute;
   logic                alarm_hit;

   alrm_picker u_picker (
      .cur      (picker_ff),
      .joy_x    (joy_x_ff),
      .joy_y    (joy_y_ff),
      .lo_level (lo_level_ff),
      .hi_level (hi_level_ff),
      .nxt      (picker_joy)
   );

   alrm_snooze u_snooze (
      .clock_hour     (hour_ff),
      .clock_minute   (minute_ff),
      .snooze_minutes (snooze_ff),
      .wake_hour      (wake_hour),
      .wake_minute    (wake_minute)
   );

   // ring only at second zero of the armed minute
   assign alarm_hit = armed_ff && (hour_ff == target_hour_ff) &&
                      (minute_ff == target_minute_ff) && (second_ff == '0);

   always_comb begin
      picker_in        = picker_ff;
      target_hour_in   = target_hour_ff;
      target_minute_in = target_minute_ff;
      armed_in         = armed_ff;
      ringing_in       = ringing_ff;
      if (in_go) begin
         unique case (req_kind_type'(type_ff))
            REQ_TICK: begin
               if (alarm_hit) begin
                  ringing_in = 1'b1;
               end
            end
            REQ_JOY: begin
               // ignore the joystick while ringing
               if (!ringing_ff) begin
                  picker_in = picker_joy;
               end
            end
            REQ_SET: begin
               if (ringing_ff) begin
                  // stop: clear ringing and armed, keep the target
                  ringing_in = 1'b0;
                  armed_in   = 1'b0;
               end else begin
                  armed_in         = 1'b1;
                  target_hour_in   = picker_ff.hour;
                  target_minute_in = picker_ff.minute;
               end
            end
            REQ_SNOOZE: begin
               if (ringing_ff) begin
                  ringing_in       = 1'b0;
                  armed_in         = 1'b1;
                  target_hour_in   = wake_hour;
                  target_minute_in = wake_minute;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         picker_ff        <= '{hour: '0, minute: '0, column: 1'b0, rearmed: 1'b1};
         target_hour_ff   <= '0;
         target_minute_ff <= '0;
         armed_ff         <= 1'b0;
         ringing_ff       <= 1'b0;
      end else begin
         picker_ff        <= picker_in;
         target_hour_ff   <= target_hour_in;
         target_minute_ff <= target_minute_in;
         armed_ff         <= armed_in;
         ringing_ff       <= ringing_in;
      end
   end

   // ------------------------------------------------------ result register
   logic                rsp_armed_ff;
   logic                rsp_ringing_ff;
   picker_type          rsp_picker_ff;
   logic [HOUR_W-1:0]   rsp_alarm_hour_ff;
   logic [MINUTE_W-1:0] rsp_alarm_minute_ff;

   // load the post-update state alongside the state registers
   always_ff @(posedge clock) begin
      if (in_go) begin
         rsp_armed_ff        <= armed_in;
         rsp_ringing_ff      <= ringing_in;
         rsp_picker_ff       <= picker_in;
         rsp_alarm_hour_ff   <= target_hour_in;
         rsp_alarm_minute_ff <= target_minute_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_alarm_armed  = rsp_armed_ff;
   assign rsp_ringing      = rsp_ringing_ff;
   assign rsp_edit_hour    = rsp_picker_ff.hour;
   assign rsp_edit_minute  = rsp_picker_ff.minute;
   assign rsp_column       = rsp_picker_ff.column;
   assign rsp_alarm_hour   = rsp_alarm_hour_ff;
   assign rsp_alarm_minute = rsp_alarm_minute_ff;

endmodule : alarm_clock_controller
`default_nettype wire
